[sv/fxalu_pkg.sv]
// fxalu_pkg: shared types, op codes and constants for the Q24.8 ALU.
// No dependencies.
package fxalu_pkg;

  localparam int unsigned FracBitsDefault = 8;
  // Divider width: holds 2*(|a| << FracBits) + |b| for FracBits up to 16, kept even.
  localparam int unsigned DivBits = 50;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TO_INT = 4'd14
  } op_t;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

  typedef struct packed {
    logic [3:0]        func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic [1:0]         error_code;
  } out_t;

  // Item travelling down the divider chain: early result plus division state.
  typedef struct packed {
    logic               valid;
    logic               is_div;
    logic               neg;
    out_t               early;
    logic [DivBits-1:0] rem;
    logic [DivBits-1:0] quo;
    logic [DivBits-1:0] den;
  } div_item_t;

endpackage

[sv/fixed_point_q24_8_alu_unit.sv]
// fixed_point_q24_8_alu_unit: top level of the signed Q24.8 ALU.
// Depends on fxalu_pkg, fxalu_front, fxalu_div_cell.
//
// Usage:
//   in  channel: in_valid / in_ready / in_data (fxalu_pkg::in_t: func, operands)
//   out channel: out_valid / out_ready / out_data (fxalu_pkg::out_t)
//   Every transaction gives exactly one result transaction, in order.
// Structure: a decode cell computes add/sub/mul/compare/min/max/inc/dec/to_int
//   and loads the divider state; then a row of identical divider cells each
//   retires two quotient bits per cycle while the chain advances (50 bits
//   -> 25 cells); the last stage applies sign and saturation to divides and
//   registers the output. Every op takes the full chain.
// Throughput: one transaction per cycle unless stalled; the chain moves as one.
// Stall: while out_ready is low and the output register is full, the chain
//   freezes and in_ready drops; no transaction is lost or repeated.
// Reset: rst (synchronous, active high) clears all valid bits; the block
//   accepts a transaction as soon as rst is low.
module fixed_point_q24_8_alu_unit #(
  parameter int unsigned FracBits = fxalu_pkg::FracBitsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fxalu_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fxalu_pkg::out_t  out_data
);

  localparam int unsigned Step = 2;
  localparam int unsigned DivBits = fxalu_pkg::DivBits;
  localparam int unsigned NumCells = DivBits / Step;

  logic advance;
  fxalu_pkg::div_item_t chain [NumCells+1];
  fxalu_pkg::out_t res;
  logic [DivBits-1:0] q;

  // Chain moves whenever the output register can take its tail item.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  fxalu_front #(.FracBits(FracBits)) u_front (
    .clk(clk), .rst(rst), .advance(advance),
    .in_take(in_valid && in_ready), .din(in_data), .dout(chain[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    fxalu_div_cell #(.Step(Step)) u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .din(chain[g]), .dout(chain[g+1])
    );
  end

  // Divide finish: sign and clamp the quotient.
  always_comb begin
    q = chain[NumCells].quo;
    res = chain[NumCells].early;
    if (chain[NumCells].is_div) begin
      res.error_code = fxalu_pkg::ERR_OK;
      if (!chain[NumCells].neg && q > DivBits'(32'h7fffffff)) begin
        res.result_value = 32'h7fffffff;
        res.error_code = fxalu_pkg::ERR_OVERFLOW;
      end else if (chain[NumCells].neg && q > DivBits'(32'h80000000)) begin
        res.result_value = 32'h80000000;
        res.error_code = fxalu_pkg::ERR_OVERFLOW;
      end else begin
        res.result_value = chain[NumCells].neg ? 32'(-q[31:0]) : q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chain[NumCells].valid;
    end
    if (advance) begin
      out_data <= res;
    end
  end

  // A stalled output must hold its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // Ready only drops when a full output is stalled.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without cause");

  // Compare flag only comes with zero value and no error.
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.compare_true |->
      out_data.result_value == 32'sd0 && out_data.error_code == fxalu_pkg::ERR_OK)
    else $error("compare result malformed");

  // Error code 3 never appears.
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.error_code != 2'd3)
    else $error("bad error code");

endmodule

[sv/fxalu_div_cell.sv]
// fxalu_div_cell: one cell of the restoring divider chain, STEP quotient bits.
// Depends on fxalu_pkg.
module fxalu_div_cell #(
  parameter int unsigned Step = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  fxalu_pkg::div_item_t  din,
  output fxalu_pkg::div_item_t  dout
);

  fxalu_pkg::div_item_t work;

  always_comb begin
    logic [fxalu_pkg::DivBits:0] trial;
    work = din;
    for (int i = 0; i < int'(Step); i++) begin
      trial = {work.rem, work.quo[fxalu_pkg::DivBits-1]};
      work.quo = {work.quo[fxalu_pkg::DivBits-2:0], 1'b0};
      if (trial >= {1'b0, work.den}) begin
        trial = trial - {1'b0, work.den};
        work.quo[0] = 1'b1;
      end
      work.rem = trial[fxalu_pkg::DivBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= din.valid;
    end
    if (advance) begin
      dout.is_div <= work.is_div;
      dout.neg    <= work.neg;
      dout.early  <= work.early;
      dout.rem    <= work.rem;
      dout.quo    <= work.quo;
      dout.den    <= work.den;
    end
  end

endmodule

[sv/fxalu_front.sv]
// fxalu_front: decode cell; computes every non-divide op and sets up division.
// Depends on fxalu_pkg.
module fxalu_front #(
  parameter int unsigned FracBits = fxalu_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_take,
  input  fxalu_pkg::in_t       din,
  output fxalu_pkg::div_item_t dout
);

  localparam int unsigned DivBits = fxalu_pkg::DivBits;
  localparam logic signed [33:0] WMax = 34'sd2147483647;
  localparam logic signed [33:0] WMin = -34'sd2147483648;

  logic signed [33:0] a_x, b_x, sum, dif, inc, dec;
  logic [31:0] mag_a, mag_b;
  logic [63:0] prod;
  logic [64:0] prod_r;
  logic [64:0] mulq;
  logic neg;
  fxalu_pkg::out_t early;
  fxalu_pkg::div_item_t item;

  function automatic fxalu_pkg::out_t sat(input logic signed [33:0] v);
    fxalu_pkg::out_t o;
    o = '0;
    if (v > WMax) begin
      o.result_value = 32'h7fffffff;
      o.error_code = fxalu_pkg::ERR_OVERFLOW;
    end else if (v < WMin) begin
      o.result_value = 32'h80000000;
      o.error_code = fxalu_pkg::ERR_OVERFLOW;
    end else begin
      o.result_value = v[31:0];
    end
    return o;
  endfunction

  always_comb begin
    a_x = 34'(din.operand_a);
    b_x = 34'(din.operand_b);
    sum = a_x + b_x;
    dif = a_x - b_x;
    inc = a_x + 34'sd1;
    dec = a_x - 34'sd1;
    mag_a = din.operand_a[31] ? 32'(-din.operand_a) : din.operand_a;
    mag_b = din.operand_b[31] ? 32'(-din.operand_b) : din.operand_b;
    neg = din.operand_a[31] ^ din.operand_b[31];
    prod = mag_a * mag_b;
    prod_r = {1'b0, prod} + ((65'd1 << FracBits) >> 1);
    mulq = prod_r >> FracBits;
    early = '0;
    case (fxalu_pkg::op_t'(din.func))
      fxalu_pkg::OP_ADD: early = sat(sum);
      fxalu_pkg::OP_SUB: early = sat(dif);
      fxalu_pkg::OP_MUL: begin
        if (!neg && mulq > 65'd2147483647) begin
          early.result_value = 32'h7fffffff;
          early.error_code = fxalu_pkg::ERR_OVERFLOW;
        end else if (neg && mulq > 65'd2147483648) begin
          early.result_value = 32'h80000000;
          early.error_code = fxalu_pkg::ERR_OVERFLOW;
        end else begin
          early.result_value = neg ? 32'(-mulq[31:0]) : mulq[31:0];
        end
      end
      fxalu_pkg::OP_DIV: begin
        if (din.operand_b == 32'sd0) early.error_code = fxalu_pkg::ERR_DIV_ZERO;
      end
      fxalu_pkg::OP_GT: early.compare_true = din.operand_a > din.operand_b;
      fxalu_pkg::OP_LT: early.compare_true = din.operand_a < din.operand_b;
      fxalu_pkg::OP_GE: early.compare_true = din.operand_a >= din.operand_b;
      fxalu_pkg::OP_LE: early.compare_true = din.operand_a <= din.operand_b;
      fxalu_pkg::OP_EQ: early.compare_true = din.operand_a == din.operand_b;
      fxalu_pkg::OP_NE: early.compare_true = din.operand_a != din.operand_b;
      fxalu_pkg::OP_MIN: early.result_value =
          (din.operand_a < din.operand_b) ? din.operand_a : din.operand_b;
      fxalu_pkg::OP_MAX: early.result_value =
          (din.operand_a > din.operand_b) ? din.operand_a : din.operand_b;
      fxalu_pkg::OP_INC: early = sat(inc);
      fxalu_pkg::OP_DEC: early = sat(dec);
      fxalu_pkg::OP_TO_INT: early.result_value = din.operand_a >>> FracBits;
      default: early = '0;
    endcase
    // Rounded quotient = floor((2*num + den) / (2*den)); dividend kept in quo.
    item.valid  = in_take;
    item.is_div = (din.func == fxalu_pkg::OP_DIV) && (din.operand_b != 32'sd0);
    item.neg    = neg;
    item.early  = early;
    item.rem    = '0;
    item.quo    = (DivBits'(mag_a) << (FracBits + 1)) + DivBits'(mag_b);
    item.den    = DivBits'({mag_b, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= item.valid;
    end
    if (advance) begin
      dout.is_div <= item.is_div;
      dout.neg    <= item.neg;
      dout.early  <= item.early;
      dout.rem    <= item.rem;
      dout.quo    <= item.quo;
      dout.den    <= item.den;
    end
  end

endmodule

[dv/tb_top.sv]
// tb_top: self-checking testbench for the signed Q24.8 fixed-point ALU.
// Depends on fxalu_pkg and fixed_point_q24_8_alu_unit; drives random and corner-case
// transactions, predicts every result in place and checks each one in order.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned FracBits = 8;
  localparam logic signed [63:0] WordMax = 64'sd2147483647;
  localparam logic signed [63:0] WordMin = -64'sd2147483648;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  fxalu_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  fxalu_pkg::out_t out_data;

  // Pending results, oldest first.
  fxalu_pkg::out_t alu_results_due[$];
  int unsigned error_count;
  // Receiver hold-off request and the stretch without random idling.
  bit hold_output;
  bit quiet_stretch;

  fixed_point_q24_8_alu_unit #(.FracBits(FracBits)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Clamp an exact result to the 32-bit word and flag an overflow.
  function automatic void saturate(input logic signed [63:0] v,
                                   output logic signed [31:0] r,
                                   inout logic [1:0] err);
    if (v > WordMax) begin
      r = WordMax[31:0];
      err = fxalu_pkg::ERR_OVERFLOW;
    end else if (v < WordMin) begin
      r = WordMin[31:0];
      err = fxalu_pkg::ERR_OVERFLOW;
    end else begin
      r = v[31:0];
    end
  endfunction

  // Exact fixed-point result of one operation.
  function automatic fxalu_pkg::out_t alu_predict(input fxalu_pkg::in_t t);
    fxalu_pkg::out_t o;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] q;
    logic signed [63:0] v;
    logic neg;
    a = 64'(t.operand_a);
    b = 64'(t.operand_b);
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    neg = (a < 0) != (b < 0);
    o = '0;
    case (t.func)
      fxalu_pkg::OP_ADD: saturate(a + b, o.result_value, o.error_code);
      fxalu_pkg::OP_SUB: saturate(a - b, o.result_value, o.error_code);
      fxalu_pkg::OP_MUL: begin
        // round half away from zero on the magnitude
        q = (ma * mb + (64'd1 << (FracBits - 1))) >> FracBits;
        v = neg ? -$signed(q) : $signed(q);
        saturate(v, o.result_value, o.error_code);
      end
      fxalu_pkg::OP_DIV: begin
        if (b == 0) begin
          o.error_code = fxalu_pkg::ERR_DIV_ZERO;
        end else begin
          q = (2 * (ma << FracBits) + mb) / (2 * mb);
          v = neg ? -$signed(q) : $signed(q);
          saturate(v, o.result_value, o.error_code);
        end
      end
      fxalu_pkg::OP_GT: o.compare_true = a > b;
      fxalu_pkg::OP_LT: o.compare_true = a < b;
      fxalu_pkg::OP_GE: o.compare_true = a >= b;
      fxalu_pkg::OP_LE: o.compare_true = a <= b;
      fxalu_pkg::OP_EQ: o.compare_true = a == b;
      fxalu_pkg::OP_NE: o.compare_true = a != b;
      fxalu_pkg::OP_MIN: o.result_value = (a < b) ? t.operand_a : t.operand_b;
      fxalu_pkg::OP_MAX: o.result_value = (a > b) ? t.operand_a : t.operand_b;
      fxalu_pkg::OP_INC: saturate(a + 1, o.result_value, o.error_code);
      fxalu_pkg::OP_DEC: saturate(a - 1, o.result_value, o.error_code);
      fxalu_pkg::OP_TO_INT: o.result_value = t.operand_a >>> FracBits;  // floor
      default: o = '0;  // unused code 15
    endcase
    return o;
  endfunction

  // Offer one transaction, with a random idle gap first, and wait for acceptance.
  task automatic send_op(input logic [3:0] func, input logic [31:0] a,
                         input logic [31:0] b);
    fxalu_pkg::in_t t;
    t.func = func;
    t.operand_a = a;
    t.operand_b = b;
    while (!quiet_stretch && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    alu_results_due.push_back(alu_predict(t));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Operands weighted toward the interesting regions.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7FFFFFFF - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $urandom_range(512) - 256;
      3: return 32'($signed($urandom_range(65535)) - 32768);
      4: return 32'h00000100 * ($urandom_range(16) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_output && (quiet_stretch || $urandom_range(99) >= 11);
    end
  end

  // Check each result transaction against the oldest prediction.
  always @(posedge clk) begin
    fxalu_pkg::out_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (alu_results_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        exp_r = alu_results_due.pop_front();
        if (out_data.result_value !== exp_r.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   exp_r.result_value, out_data.result_value);
          error_count++;
        end
        if (out_data.compare_true !== exp_r.compare_true) begin
          $display("%0t: compare_true expected %b actual %b", $time,
                   exp_r.compare_true, out_data.compare_true);
          error_count++;
        end
        if (out_data.error_code !== exp_r.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $time,
                   exp_r.error_code, out_data.error_code);
          error_count++;
        end
      end
    end
  end

  // Corner operands for every operation, plus unused code and rounding ties.
  task automatic test_directed();
    logic [31:0] corners[6];
    corners = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1, 32'hFFFFFFFF, 32'h00000100};
    for (int f = 0; f <= 15; f++) begin
      send_op(4'(f), corners[f % 6], corners[(f + 1) % 6]);
    end
    send_op(fxalu_pkg::OP_DIV, 32'h00000500, 32'h0);        // divide by zero
    send_op(fxalu_pkg::OP_MUL, 32'h00000180, 32'h00000001); // tie rounds away from zero
    send_op(fxalu_pkg::OP_MUL, 32'hFFFFFE80, 32'h00000001); // negative tie
    send_op(fxalu_pkg::OP_DIV, 32'h80000000, 32'h00000001); // quotient overflow
    send_op(fxalu_pkg::OP_INC, 32'h7FFFFFFF, 32'h0);
    send_op(fxalu_pkg::OP_DEC, 32'h80000000, 32'h0);
    send_op(fxalu_pkg::OP_TO_INT, 32'hFFFFFF01, 32'h0);     // floor of negative
    send_op(fxalu_pkg::OP_EQ, 32'h12345678, 32'h12345678);
  endtask

  // Random mix of all codes over weighted operands.
  task automatic test_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_op(4'($urandom_range(15)), pick_operand(), pick_operand());
    end
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure();
    hold_output = 1'b1;
    fork
      begin
        repeat (80) @(posedge clk);
        hold_output = 1'b0;
      end
      test_random(60);
    join
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_full_rate();
    quiet_stretch = 1'b1;
    test_random(200);
    quiet_stretch = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    hold_output = 1'b0;
    quiet_stretch = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    test_full_rate();
    test_random(400);
    in_valid <= 1'b0;
    while (alu_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
